// ===== rtl/core/ile_pkg.sv =====
// Shared types and constants for the indexed list engine.
package ile_pkg;

	// Default number of slots in the cell row
	localparam int unsigned CapacityDefault = 64;

	// Width of one stored value
	localparam int unsigned ValW = 32;

	// Command codes on the func field
	typedef enum logic [2:0] {
		FN_READ     = 3'd0,
		FN_INS_HEAD = 3'd1,
		FN_INS_TAIL = 3'd2,
		FN_INS_POS  = 3'd3,
		FN_DELETE   = 3'd4
	} func_t;

	// Result status codes
	typedef enum logic [1:0] {
		ST_DONE  = 2'd0,
		ST_RANGE = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	// Operation broadcast to every cell of the row
	typedef enum logic [1:0] {
		LOP_NONE   = 2'd0,
		LOP_INSERT = 2'd1,
		LOP_DELETE = 2'd2
	} list_op_t;

	// Decoded command from the controller
	typedef struct packed {
		list_op_t op;
		logic     rd_hit;
		logic     rd_miss;
		status_t  status;
	} cmd_t;

endpackage

// ===== rtl/core/ile_cell.sv =====
// One slot of the list: holds a value, loads, or takes a neighbor's value.
module ile_cell
	import ile_pkg::*;
#(
	parameter int unsigned CNT_W = 7,
	parameter int unsigned IDX   = 0
) (
	input  logic              clk,
	input  list_op_t          op,
	input  logic [CNT_W-1:0]  pos,
	input  logic [ValW-1:0]   new_value,
	input  logic [ValW-1:0]   left_value,
	input  logic [ValW-1:0]   right_value,
	output logic [ValW-1:0]   value_q,
	output logic [ValW-1:0]   rd_value
);

	localparam logic [CNT_W-1:0] IdxC = CNT_W'(IDX);

	logic [ValW-1:0] value_nxt;

	// Pick the next slot content from the broadcast operation
	always_comb begin
		value_nxt = value_q;
		case (op)
			LOP_INSERT: begin
				if (IdxC == pos) begin
					value_nxt = new_value;
				end else if (IdxC > pos) begin
					value_nxt = left_value;
				end
			end
			LOP_DELETE: begin
				if (IdxC >= pos) begin
					value_nxt = right_value;
				end
			end
			default: begin
				value_nxt = value_q;
			end
		endcase
	end

	// Hold the slot value
	always_ff @(posedge clk) begin
		value_q <= value_nxt;
	end

	// Drive this slot onto the read bus when addressed
	assign rd_value = (IdxC == pos) ? value_q : '0;

endmodule

// ===== rtl/core/ile_ctrl.sv =====
// Command decode: range and full checks, target position and next count.
module ile_ctrl
	import ile_pkg::*;
#(
	parameter int unsigned CAPACITY = CapacityDefault,
	parameter int unsigned CNT_W    = $clog2(CAPACITY + 1)
) (
	input  logic [2:0]        func,
	input  logic [CNT_W-1:0]  position,
	input  logic [CNT_W-1:0]  count_q,
	output cmd_t              ctl,
	output logic [CNT_W-1:0]  op_pos,
	output logic [CNT_W-1:0]  count_nxt
);

	localparam logic [CNT_W-1:0] CapC = CNT_W'(CAPACITY);

	logic full;

	assign full = (count_q == CapC);

	// Decode the command against the current count
	always_comb begin
		ctl.op      = LOP_NONE;
		ctl.rd_hit  = 1'b0;
		ctl.rd_miss = 1'b0;
		ctl.status  = ST_DONE;
		op_pos      = position;
		case (func)
			FN_READ: begin
				if (position < count_q) begin
					ctl.rd_hit = 1'b1;
				end else begin
					ctl.rd_miss = 1'b1;
					ctl.status  = ST_RANGE;
				end
			end
			FN_INS_HEAD: begin
				op_pos = '0;
				if (full) begin
					ctl.status = ST_FULL;
				end else begin
					ctl.op = LOP_INSERT;
				end
			end
			FN_INS_TAIL: begin
				op_pos = count_q;
				if (full) begin
					ctl.status = ST_FULL;
				end else begin
					ctl.op = LOP_INSERT;
				end
			end
			FN_INS_POS: begin
				if (position > count_q) begin
					ctl.status = ST_RANGE;
				end else if (full) begin
					ctl.status = ST_FULL;
				end else begin
					ctl.op = LOP_INSERT;
				end
			end
			FN_DELETE: begin
				if (position >= count_q) begin
					ctl.status = ST_RANGE;
				end else begin
					ctl.op = LOP_DELETE;
				end
			end
			default: begin
				ctl.op = LOP_NONE;
			end
		endcase
	end

	// Advance the element count
	always_comb begin
		case (ctl.op)
			LOP_INSERT: count_nxt = count_q + CNT_W'(1);
			LOP_DELETE: count_nxt = count_q - CNT_W'(1);
			default:    count_nxt = count_q;
		endcase
	end

endmodule

// ===== rtl/core/indexed_list_engine.sv =====
// Top level of the indexed list engine: controller, cell row and result register.
//
// An ordered list of up to CAPACITY signed 32-bit values kept in a row of cells.
// Input channel (in_valid/in_ready) carries one command per transaction: func,
// position and item_value. Output channel (out_valid/out_ready) returns one
// result per command: read_value, status and element_count after the command.
// For each command the controller checks position against the count, the
// cells each compare their index with the target position and hold, load or
// take a neighbor's value in the same cycle, and the read value is collected
// from the addressed cell. The result is registered; throughput is one command
// per cycle while the output side takes each result.
// A result that waits in the output register while out_ready is low still lets
// a new command in when out_ready rises in the same cycle; otherwise in_ready
// drops until the result is taken.
// Reset empties the list and the output register; slot contents are not cleared
// and are only ever read below the element count.
module indexed_list_engine
	import ile_pkg::*;
#(
	parameter int unsigned CAPACITY = CapacityDefault,
	parameter int unsigned CNT_W    = $clog2(CAPACITY + 1)
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic [2:0]              func,
	input  logic [CNT_W-1:0]        position,
	input  logic signed [ValW-1:0]  item_value,
	output logic                    out_valid,
	input  logic                    out_ready,
	output logic signed [ValW-1:0]  read_value,
	output logic [1:0]              status,
	output logic [CNT_W-1:0]        element_count
);

	logic                    accept;
	logic                    out_valid_q;
	logic [CNT_W-1:0]        count_q;
	logic [CNT_W-1:0]        count_nxt;
	logic [CNT_W-1:0]        op_pos;
	cmd_t                    ctl;
	list_op_t                cell_op;
	logic [ValW-1:0]         cell_val   [CAPACITY];
	logic [ValW-1:0]         cell_rd    [CAPACITY];
	logic [ValW-1:0]         rd_bus;
	logic [ValW-1:0]         rd_sel;
	logic signed [ValW-1:0]  read_value_q;
	status_t                 status_q;
	logic [CNT_W-1:0]        element_count_q;

	assign in_ready = !out_valid_q || out_ready;
	assign accept   = in_valid && in_ready;

	ile_ctrl #(
		.CAPACITY (CAPACITY),
		.CNT_W    (CNT_W)
	) u_ctrl (
		.func      (func),
		.position  (position),
		.count_q   (count_q),
		.ctl       (ctl),
		.op_pos    (op_pos),
		.count_nxt (count_nxt)
	);

	// Drop the row operation unless a transaction is taken
	assign cell_op = accept ? ctl.op : LOP_NONE;

	// Build the row of cells, each wired to its neighbors
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic [ValW-1:0] left_v;
		logic [ValW-1:0] right_v;

		if (i == 0) begin : g_first
			assign left_v = cell_val[i];
		end else begin : g_left
			assign left_v = cell_val[i-1];
		end

		if (i == CAPACITY - 1) begin : g_last
			assign right_v = cell_val[i];
		end else begin : g_right
			assign right_v = cell_val[i+1];
		end

		ile_cell #(
			.CNT_W (CNT_W),
			.IDX   (i)
		) u_cell (
			.clk         (clk),
			.op          (cell_op),
			.pos         (op_pos),
			.new_value   (item_value),
			.left_value  (left_v),
			.right_value (right_v),
			.value_q     (cell_val[i]),
			.rd_value    (cell_rd[i])
		);
	end

	// Merge the addressed cell onto the read bus
	always_comb begin
		rd_bus = '0;
		for (int unsigned k = 0; k < CAPACITY; k++) begin
			rd_bus = rd_bus | cell_rd[k];
		end
	end

	// Select the read result field
	always_comb begin
		if (ctl.rd_hit) begin
			rd_sel = rd_bus;
		end else if (ctl.rd_miss) begin
			rd_sel = '1;
		end else begin
			rd_sel = '0;
		end
	end

	// Hold the element count and the output valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				count_q     <= count_nxt;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Capture the result of each transaction
	always_ff @(posedge clk) begin
		if (accept) begin
			read_value_q    <= rd_sel;
			status_q        <= ctl.status;
			element_count_q <= count_nxt;
		end
	end

	assign out_valid     = out_valid_q;
	assign read_value    = read_value_q;
	assign status        = status_q;
	assign element_count = element_count_q;

endmodule

// ===== tb/sv/indexed_list_checker.sv =====
// Checker for the indexed list engine: predicts each result and compares it with the output.
`timescale 1ns / 100ps

module indexed_list_checker
	import ile_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	input  logic                   in_ready,
	input  logic [2:0]             func,
	input  logic [6:0]             position,
	input  logic signed [ValW-1:0] item_value,
	input  logic                   out_valid,
	input  logic                   out_ready,
	input  logic signed [ValW-1:0] read_value,
	input  logic [1:0]             status,
	input  logic [6:0]             element_count,
	output int                     fail_count,
	output int                     pending_count,
	output logic [6:0]             list_len
);

	localparam int unsigned Cap = CapacityDefault;

	typedef struct packed {
		logic signed [ValW-1:0] rd;
		logic [1:0]             st;
		logic [6:0]             cnt;
	} list_result_t;

	// Shadow copy of the list contents and its length
	logic signed [ValW-1:0] shadow_slots [Cap];
	int unsigned            shadow_len;

	// Results predicted but not yet seen on the output channel
	list_result_t expected_results [$];

	// Apply one command to the shadow list and work out its result
	task automatic apply_list_command(input logic [2:0] f, input logic [6:0] p,
			input logic signed [ValW-1:0] v, output list_result_t res);
		int unsigned tgt;
		res.rd = '0;
		res.st = ST_DONE;
		case (f)
			FN_READ: begin
				if (p < shadow_len) begin
					res.rd = shadow_slots[p];
				end else begin
					res.rd = -1;
					res.st = ST_RANGE;
				end
			end
			FN_INS_HEAD, FN_INS_TAIL, FN_INS_POS: begin
				if (f == FN_INS_HEAD)
					tgt = 0;
				else if (f == FN_INS_TAIL)
					tgt = shadow_len;
				else
					tgt = p;
				// range test comes ahead of the full test
				if (f == FN_INS_POS && p > shadow_len) begin
					res.st = ST_RANGE;
				end else if (shadow_len >= Cap) begin
					res.st = ST_FULL;
				end else begin
					for (int unsigned i = shadow_len; i > tgt; i--)
						shadow_slots[i] = shadow_slots[i-1];
					shadow_slots[tgt] = v;
					shadow_len++;
				end
			end
			FN_DELETE: begin
				if (p >= shadow_len) begin
					res.st = ST_RANGE;
				end else begin
					for (int unsigned i = p; i + 1 < shadow_len; i++)
						shadow_slots[i] = shadow_slots[i+1];
					shadow_len--;
				end
			end
			default: ;
		endcase
		res.cnt = shadow_len[6:0];
	endtask

	// Retire output transactions first, then predict the input transaction
	always @(posedge clk or negedge arst_n) begin
		list_result_t exp_res;
		list_result_t act_res;
		if (!arst_n) begin
			expected_results.delete();
			shadow_len = 0;
			fail_count <= 0;
			pending_count <= 0;
			list_len <= '0;
		end else begin
			if (out_valid && out_ready) begin
				act_res = '{rd: read_value, st: status, cnt: element_count};
				if (expected_results.size() == 0) begin
					$display("%0t: unexpected result read_value=%0d status=%0d count=%0d",
						$time, read_value, status, element_count);
					fail_count <= fail_count + 1;
				end else begin
					exp_res = expected_results.pop_front();
					if (act_res !== exp_res) begin
						$display("%0t: mismatch expected value=%0d status=%0d count=%0d, actual value=%0d status=%0d count=%0d",
							$time, exp_res.rd, exp_res.st, exp_res.cnt,
							act_res.rd, act_res.st, act_res.cnt);
						fail_count <= fail_count + 1;
					end
				end
			end
			if (in_valid && in_ready) begin
				apply_list_command(func, position, item_value, exp_res);
				expected_results.push_back(exp_res);
			end
			pending_count <= expected_results.size();
			list_len <= shadow_len[6:0];
		end
	end

endmodule

// ===== tb/sv/indexed_list_engine_tb.sv =====
// Testbench top for the indexed list engine: stimulus, output flow control and verdict.
`timescale 1ns / 100ps

module indexed_list_engine_tb;
	import ile_pkg::*;

	localparam int unsigned Cap         = CapacityDefault;
	localparam int unsigned PosMax      = 127;
	localparam logic [2:0]  FuncCodeMax = 3'd7;
	localparam int          ItemTarget  = 1800;

	logic                   clk = 1'b0;
	logic                   arst_n;
	logic                   in_valid;
	logic                   in_ready;
	logic [2:0]             func;
	logic [6:0]             position;
	logic signed [ValW-1:0] item_value;
	logic                   out_valid;
	logic                   out_ready;
	logic signed [ValW-1:0] read_value;
	logic [1:0]             status;
	logic [6:0]             element_count;

	int         fail_count;
	int         pending_count;
	logic [6:0] list_len;

	int items_sent   = 0;
	bit idle_enabled = 1'b1;

	indexed_list_engine u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.func          (func),
		.position      (position),
		.item_value    (item_value),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.read_value    (read_value),
		.status        (status),
		.element_count (element_count)
	);

	indexed_list_checker u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.func          (func),
		.position      (position),
		.item_value    (item_value),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.read_value    (read_value),
		.status        (status),
		.element_count (element_count),
		.fail_count    (fail_count),
		.pending_count (pending_count),
		.list_len      (list_len)
	);

	// 8 ns clock
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Give up after a generous fixed time
	initial begin
		#2000000;
		$display("indexed_list_engine_tb: done, errors");
		$finish;
	end

	// Drive one input transaction and hold it until accepted, then maybe idle
	task automatic send_command(input logic [2:0] f, input logic [6:0] p,
			input logic signed [ValW-1:0] v);
		in_valid <= 1'b1;
		func <= f;
		position <= p;
		item_value <= v;
		do @(posedge clk); while (!in_ready);
		items_sent++;
		if (idle_enabled && $urandom_range(0, 5) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 17)) @(posedge clk);
		end
	endtask

	// Hold the sender off until every expected result has come back
	task automatic drain_results();
		in_valid <= 1'b0;
		do @(posedge clk); while (pending_count != 0);
	endtask

	// Mostly a position up to hi, sometimes anywhere in the field
	function automatic logic [6:0] pick_position(input int unsigned hi);
		if ($urandom_range(0, 99) < 85)
			return 7'($urandom_range(0, hi));
		return 7'($urandom_range(0, PosMax));
	endfunction

	// One command of random kind, positions biased to the current length
	task automatic send_random_command();
		int unsigned len;
		int unsigned pick;
		len = list_len;
		pick = $urandom_range(0, 99);
		if (pick < 5)
			send_command(3'($urandom_range(FN_DELETE + 1, FuncCodeMax)),
				7'($urandom_range(0, PosMax)), $urandom);
		else if (pick < 25)
			send_command(FN_READ, pick_position(len > 0 ? len - 1 : 0), $urandom);
		else if (pick < 35)
			send_command(FN_INS_HEAD, 7'($urandom_range(0, PosMax)), $urandom);
		else if (pick < 45)
			send_command(FN_INS_TAIL, 7'($urandom_range(0, PosMax)), $urandom);
		else if (pick < 70)
			send_command(FN_INS_POS, pick_position(len), $urandom);
		else
			send_command(FN_DELETE, pick_position(len > 0 ? len - 1 : 0), $urandom);
	endtask

	// Stall the output side in random bursts while idling is on
	initial begin
		out_ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			out_ready <= 1'b1;
			repeat ($urandom_range(0, 40)) @(posedge clk);
			if (idle_enabled && $urandom_range(0, 2) == 0) begin
				@(posedge clk);
				out_ready <= 1'b0;
				repeat ($urandom_range(0, 16)) @(posedge clk);
			end
		end
	end

	// Reset, directed commands, random sequences, then drain and report
	initial begin
		int unsigned kind;
		bit          pressure_done;
		pressure_done = 1'b0;
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		func <= FN_READ;
		position <= '0;
		item_value <= '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty list: every position is out of range
		send_command(FN_READ, 7'd0, $urandom);
		send_command(FN_DELETE, 7'd0, $urandom);
		send_command(FN_INS_POS, 7'd1, $urandom);
		// build a short list with extreme values at every insert kind
		send_command(FN_INS_POS, 7'd0, 32'sh7FFF_FFFF);
		send_command(FN_INS_HEAD, 7'd0, 32'sh8000_0000);
		send_command(FN_INS_TAIL, 7'd127, 32'shFFFF_FFFF);
		send_command(FN_INS_POS, 7'd3, 32'sh0);
		send_command(FN_INS_POS, 7'd1, 32'sh5555_5555);
		send_command(FN_INS_POS, 7'd6, 32'shAAAA_AAAA);
		for (int i = 0; i < 5; i++)
			send_command(FN_READ, 7'(i), $urandom);
		// reads past the end
		send_command(FN_READ, 7'd5, $urandom);
		send_command(FN_READ, 7'(Cap), $urandom);
		send_command(FN_READ, 7'd127, $urandom);
		// deletes out of range, at the tail and at the head
		send_command(FN_DELETE, 7'd127, $urandom);
		send_command(FN_DELETE, 7'd5, $urandom);
		send_command(FN_DELETE, 7'd4, $urandom);
		send_command(FN_DELETE, 7'd0, $urandom);
		// unused function codes
		for (int f = FN_DELETE + 1; f <= FuncCodeMax; f++)
			send_command(3'(f), 7'($urandom_range(0, PosMax)), $urandom);
		drain_results();

		while (items_sent < ItemTarget) begin
			kind = $urandom_range(0, 9);
			if (kind < 2) begin
				// fill past capacity to hit the full store
				repeat (72) begin
					case ($urandom_range(0, 2))
						0: send_command(FN_INS_HEAD, 7'($urandom_range(0, PosMax)), $urandom);
						1: send_command(FN_INS_TAIL, 7'($urandom_range(0, PosMax)), $urandom);
						default: send_command(FN_INS_POS, pick_position(list_len), $urandom);
					endcase
				end
			end else if (kind < 4) begin
				// drain the list toward empty, with reads mixed in
				repeat (72) begin
					if ($urandom_range(0, 4) == 0)
						send_command(FN_READ, pick_position(list_len > 0 ? list_len - 1 : 0),
							$urandom);
					else
						send_command(FN_DELETE, pick_position(list_len > 0 ? list_len - 1 : 0),
							$urandom);
				end
			end else begin
				repeat (40) send_random_command();
			end
			if (!pressure_done && items_sent > ItemTarget / 2) begin
				drain_results();
				pressure_done = 1'b1;
			end
			if (items_sent > ItemTarget * 4 / 5)
				idle_enabled = 1'b0;
		end

		drain_results();
		repeat (4) @(posedge clk);
		if (fail_count == 0) begin
			$display("indexed_list_engine_tb: done, clean");
		end else begin
			$display("indexed_list_engine_tb: done, errors");
		end
		$finish;
	end

endmodule

// ===== indexed_list_engine.f =====
rtl/core/ile_pkg.sv
rtl/core/ile_cell.sv
rtl/core/ile_ctrl.sv
rtl/core/indexed_list_engine.sv
tb/sv/indexed_list_checker.sv
tb/sv/indexed_list_engine_tb.sv
